>>> src/siocfg_pkg.sv
// siocfg_pkg: types, constants and helpers of the super i/o configuration port
// used by siocfg_decode and superio_config_unlock_regs; no dependencies
package siocfg_pkg;

   localparam int unsigned DATA_W   = 8;
   localparam int unsigned ADDR_W   = 8;
   localparam int unsigned BASE_W   = 10;
   localparam int unsigned IRQ_W    = 4;
   localparam int unsigned MODE_W   = 3;
   localparam int unsigned DMA_W    = 3;
   localparam int unsigned REGS     = 256;
   localparam int unsigned RSP_W    = 64;

   // unlock keys and the index loaded by the second key
   localparam logic [DATA_W-1:0] KEY_FIRST       = 8'h51;
   localparam logic [DATA_W-1:0] KEY_SECOND      = 8'h29;
   localparam logic [ADDR_W-1:0] INDEX_AFTER_KEY = 8'h93;
   localparam logic [DATA_W-1:0] IDLE_READ       = 8'hff;

   // register addresses that feed the resource map
   localparam logic [ADDR_W-1:0] REG_FDC   = 8'h66;
   localparam logic [ADDR_W-1:0] REG_BASES = 8'h77;
   localparam logic [ADDR_W-1:0] REG_UART0 = 8'h88;
   localparam logic [ADDR_W-1:0] REG_UART1 = 8'h99;
   localparam logic [ADDR_W-1:0] REG_LPTEN = 8'haa;
   localparam logic [ADDR_W-1:0] REG_LPT   = 8'hbb;
   localparam logic [ADDR_W-1:0] REG_IRQ   = 8'hcc;

   // register reset values
   localparam logic [DATA_W-1:0] RST_ENABLE = 8'h01;
   localparam logic [DATA_W-1:0] RST_BASES  = 8'h10;
   localparam logic [DATA_W-1:0] RST_LPT    = 8'h48;
   localparam logic [DMA_W-1:0]  RST_DMA    = 3'd3;

   // decoded i/o bases and readouts
   localparam logic [BASE_W-1:0] BASE_LPT_3BC = 10'h3bc;
   localparam logic [BASE_W-1:0] BASE_LPT_378 = 10'h378;
   localparam logic [BASE_W-1:0] BASE_LPT_278 = 10'h278;
   localparam logic [BASE_W-1:0] BASE_COM_3E8 = 10'h3e8;
   localparam logic [BASE_W-1:0] BASE_COM_3F8 = 10'h3f8;
   localparam logic [BASE_W-1:0] BASE_COM_2E8 = 10'h2e8;
   localparam logic [BASE_W-1:0] BASE_COM_2F8 = 10'h2f8;
   localparam logic [IRQ_W-1:0]  LPT_IRQ5     = 4'd5;
   localparam logic [IRQ_W-1:0]  LPT_IRQ7     = 4'd7;
   localparam logic [DATA_W-1:0] CNFGB_IRQ5   = 8'h38;
   localparam logic [DATA_W-1:0] CNFGB_IRQ7   = 8'h08;

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_KEY   = 2'd1,
      PH_INDEX = 2'd2,
      PH_DATA  = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      RD_ZERO,
      RD_ONES,
      RD_INDEX,
      RD_REG
   } rd_src_type;

   // copies of the registers that the resource map decodes
   typedef struct packed {
      logic [DATA_W-1:0] r66;
      logic [DATA_W-1:0] r77;
      logic [DATA_W-1:0] r88;
      logic [DATA_W-1:0] r99;
      logic [DATA_W-1:0] raa;
      logic [DATA_W-1:0] rbb;
      logic [DATA_W-1:0] rcc;
   } shadow_type;

   typedef struct packed {
      logic [DATA_W-1:0] lpt_cnfgb;
      logic [MODE_W-1:0] lpt_mode;
      logic [IRQ_W-1:0]  lpt_irq;
      logic [BASE_W-1:0] lpt_base;
      logic              lpt_enable;
      logic [BASE_W-1:0] uart1_base;
      logic              uart1_enable;
      logic [BASE_W-1:0] uart0_base;
      logic              uart0_enable;
      logic              fdc_enable;
   } map_type;

   localparam shadow_type SHADOW_RESET = '{
      r66: RST_ENABLE, r77: RST_BASES, r88: RST_ENABLE, r99: RST_ENABLE,
      raa: RST_ENABLE, rbb: RST_LPT, rcc: '0};

   // reset value of any register file entry
   function automatic logic [DATA_W-1:0] reg_reset_value(input logic [ADDR_W-1:0] addr);
      logic [DATA_W-1:0] val;
      case (addr)
         REG_FDC, REG_UART0, REG_UART1, REG_LPTEN: val = RST_ENABLE;
         REG_BASES: val = RST_BASES;
         REG_LPT:   val = RST_LPT;
         default:   val = '0;
      endcase
      return val;
   endfunction

endpackage

>>> src/superio_config_unlock_regs.sv
// superio_config_unlock_regs: keyed configuration port with 256-byte register file
// depends on siocfg_pkg and siocfg_decode
//
//  channel   dir  handshake            payload
//  req_      in   req_tvalid/tready    tdata: write_data; tuser: kind (1 = read)
//  rsp_      out  rsp_tvalid/tready    tdata: read_data, phase, resource map
//  csr_      in   csr_valid/ready      csr_data: ecp dma channel
//
// one word per cycle while no held result stalls; a word is decoded in the cycle
// it is accepted and its result sits in the output register from the next cycle on
// the register file is a 256-entry memory with one read port; its read data is
// registered together with the rest of the result
// reset (synchronous) restores phase, index, register file contents (through
// per-entry valid bits) and the dma channel together, with no clearing pass
// req_tready drops only while a result is held and rsp_tready is low
module superio_config_unlock_regs (
   input  logic                            clock,
   input  logic                            reset,
   // request words
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [siocfg_pkg::DATA_W-1:0]   req_tdata,   // [7:0] write_data
   input  logic [0:0]                      req_tuser,   // [0] kind
   // response words
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [siocfg_pkg::RSP_W-1:0]    rsp_tdata,   // [7:0] read_data, [9:8] phase,
                                                        // [10] fdc_enable, [11] uart0_enable,
                                                        // [21:12] uart0_base, [22] uart1_enable,
                                                        // [32:23] uart1_base, [33] lpt_enable,
                                                        // [43:34] lpt_base, [47:44] lpt_irq,
                                                        // [50:48] lpt_mode, [58:51] lpt_cnfgb,
                                                        // [63:59] zero
   // dma channel jumper
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [siocfg_pkg::DMA_W-1:0]    csr_data
);
   import siocfg_pkg::*;

   // handshake
   logic accept;
   logic is_read;
   logic [DATA_W-1:0] wdata;

   // port state
   phase_type         phase_ff, phase_in;
   logic [ADDR_W-1:0] index_ff, index_in;
   logic [DMA_W-1:0]  dma_ff;
   shadow_type        shadow_ff, shadow_in;

   // fsm outputs
   logic       index_we;
   logic       reg_we;
   rd_src_type rd_src;

   // register file with valid bits; an entry never written reads its reset value
   logic [DATA_W-1:0] mem [REGS];
   logic [REGS-1:0]   valid_ff;

   // output register
   logic              rsp_valid_ff;
   logic [DATA_W-1:0] rd_byte_ff, rd_byte_in;
   logic              rd_mem_ff;
   logic [DATA_W-1:0] mem_q_ff;
   logic              mem_valid_ff;
   logic [DATA_W-1:0] mem_rst_ff;
   phase_type         rsp_phase_ff;
   map_type           map_ff, map_in;
   logic [DATA_W-1:0] read_data;

   assign is_read    = req_tuser[0];
   assign wdata      = req_tdata;
   assign req_tready = ~rsp_valid_ff | rsp_tready;
   assign accept     = req_tvalid & req_tready;
   assign csr_ready  = 1'b1;

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (is_read) begin
         if (phase_ff == PH_DATA) begin
            phase_in = PH_IDLE;
         end
      end else begin
         case (phase_ff)
            PH_IDLE:  phase_in = (wdata == KEY_FIRST) ? PH_KEY : PH_IDLE;
            PH_KEY:   phase_in = (wdata == KEY_SECOND) ? PH_INDEX : PH_IDLE;
            PH_INDEX: phase_in = PH_DATA;
            PH_DATA:  phase_in = PH_IDLE;
            default:  phase_in = PH_IDLE;
         endcase
      end
   end

   // fsm outputs: index load, register write and read source
   always_comb begin
      index_we = 1'b0;
      index_in = wdata;
      reg_we   = 1'b0;
      rd_src   = RD_ZERO;
      if (is_read) begin
         case (phase_ff)
            PH_INDEX: rd_src = RD_INDEX;
            PH_DATA:  rd_src = RD_REG;
            default:  rd_src = RD_ONES;
         endcase
      end else begin
         case (phase_ff)
            PH_KEY: begin
               // a correct second key points the index at the default register
               index_we = (wdata == KEY_SECOND);
               index_in = INDEX_AFTER_KEY;
            end
            PH_INDEX: index_we = 1'b1;
            PH_DATA:  reg_we   = 1'b1;
            default: begin
               index_we = 1'b0;
               reg_we   = 1'b0;
            end
         endcase
      end
   end

   // shadow copies follow writes to the decoded registers
   always_comb begin
      shadow_in = shadow_ff;
      if (reg_we) begin
         case (index_ff)
            REG_FDC:   shadow_in.r66 = wdata;
            REG_BASES: shadow_in.r77 = wdata;
            REG_UART0: shadow_in.r88 = wdata;
            REG_UART1: shadow_in.r99 = wdata;
            REG_LPTEN: shadow_in.raa = wdata;
            REG_LPT:   shadow_in.rbb = wdata;
            REG_IRQ:   shadow_in.rcc = wdata;
            default:   shadow_in = shadow_ff;
         endcase
      end
   end

   always_comb begin
      case (rd_src)
         RD_ONES:  rd_byte_in = IDLE_READ;
         RD_INDEX: rd_byte_in = index_ff;
         default:  rd_byte_in = '0;
      endcase
   end

   siocfg_decode u_decode (
      .regs    (shadow_in),
      .ecp_dma (dma_ff),
      .map     (map_in)
   );

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         index_ff     <= '0;
         shadow_ff    <= SHADOW_RESET;
         valid_ff     <= '0;
         dma_ff       <= RST_DMA;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid & csr_ready) begin
            dma_ff <= csr_data;
         end
         if (accept) begin
            phase_ff  <= phase_in;
            shadow_ff <= shadow_in;
            if (index_we) begin
               index_ff <= index_in;
            end
            if (reg_we) begin
               valid_ff[index_ff] <= 1'b1;
            end
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // register file: one write port, one registered read port, both at the index
   always_ff @(posedge clock) begin
      if (accept & reg_we) begin
         mem[index_ff] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mem_q_ff <= mem[index_ff];
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         mem_valid_ff <= valid_ff[index_ff];
         mem_rst_ff   <= reg_reset_value(index_ff);
         rd_mem_ff    <= (rd_src == RD_REG);
         rd_byte_ff   <= rd_byte_in;
         rsp_phase_ff <= phase_in;
         map_ff       <= map_in;
      end
   end

   assign read_data = rd_mem_ff ? (mem_valid_ff ? mem_q_ff : mem_rst_ff) : rd_byte_ff;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0,
                        map_ff.lpt_cnfgb, map_ff.lpt_mode, map_ff.lpt_irq, map_ff.lpt_base,
                        map_ff.lpt_enable, map_ff.uart1_base, map_ff.uart1_enable,
                        map_ff.uart0_base, map_ff.uart0_enable, map_ff.fdc_enable,
                        rsp_phase_ff, read_data};

endmodule

>>> src/siocfg_decode.sv
// siocfg_decode: resource map decode from the shadowed configuration registers
// depends on siocfg_pkg
module siocfg_decode (
   input  siocfg_pkg::shadow_type             regs,
   input  logic [siocfg_pkg::DMA_W-1:0]       ecp_dma,
   output siocfg_pkg::map_type                map
);
   import siocfg_pkg::*;

   logic              irq5;
   logic [DATA_W-1:0] dma_bits;

   assign irq5     = regs.rcc[7];
   // dma channels 4 and up read back as zero
   assign dma_bits = ecp_dma[DMA_W-1] ? '0 : DATA_W'(ecp_dma);

   always_comb begin
      map.fdc_enable   = regs.r66[0];
      map.uart0_enable = regs.r88[0];
      map.uart0_base   = regs.r77[4] ? BASE_COM_3E8 : BASE_COM_3F8;
      map.uart1_enable = regs.r99[0];
      map.uart1_base   = regs.r77[1] ? BASE_COM_2E8 : BASE_COM_2F8;
      map.lpt_enable   = regs.raa[0];
      case (regs.rbb[3:2])
         2'b10:   map.lpt_base = BASE_LPT_378;
         2'b11:   map.lpt_base = BASE_LPT_278;
         default: map.lpt_base = BASE_LPT_3BC;
      endcase
      map.lpt_irq   = irq5 ? LPT_IRQ5 : LPT_IRQ7;
      map.lpt_mode  = {~regs.rbb[6], regs.rbb[5], regs.rbb[4]};
      map.lpt_cnfgb = (irq5 ? CNFGB_IRQ5 : CNFGB_IRQ7) | dma_bits;
   end

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// tb: self-checking bench for superio_config_unlock_regs (keyed config port, register file)
// depends on siocfg_pkg and the block itself; reads no files, needs no arguments
module tb;
   import siocfg_pkg::*;

   // access kinds carried in req_tuser
   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_READ  = 1'b1;

   localparam int WATCHDOG_LIMIT  = 5000;
   localparam int WORDS_PER_PHASE = 200;
   localparam int SETTLE_CYCLES   = 8;

   // one result word, split into its fields
   typedef struct packed {
      logic [7:0] read_data;
      logic [1:0] phase;
      logic       fdc_en;
      logic       uart0_en;
      logic [9:0] uart0_base;
      logic       uart1_en;
      logic [9:0] uart1_base;
      logic       lpt_en;
      logic [9:0] lpt_base;
      logic [3:0] lpt_irq;
      logic [2:0] lpt_mode;
      logic [7:0] lpt_cnfgb;
   } port_result_type;

   // directed row: access plus, where obvious, the read data and phase it must give
   typedef struct packed {
      logic       kind;
      logic [7:0] data;
      logic       typed;
      logic [7:0] want_rd;
      logic [1:0] want_phase;
   } stim_row_type;

   localparam stim_row_type DIRECTED [25] = '{
      // read straight after reset, port locked
      '{KIND_READ,  8'h00, 1'b1, 8'hff, PH_IDLE},
      // wrong first key keeps the port idle
      '{KIND_WRITE, 8'h00, 1'b1, 8'h00, PH_IDLE},
      '{KIND_WRITE, KEY_FIRST, 1'b1, 8'h00, PH_KEY},
      // idle read with first key seen
      '{KIND_READ,  8'hff, 1'b1, 8'hff, PH_KEY},
      // wrong second key drops back to idle
      '{KIND_WRITE, 8'hff, 1'b1, 8'h00, PH_IDLE},
      '{KIND_WRITE, KEY_FIRST, 1'b1, 8'h00, PH_KEY},
      '{KIND_WRITE, KEY_SECOND, 1'b1, 8'h00, PH_INDEX},
      // index read gives the index loaded by the second key
      '{KIND_READ,  8'h00, 1'b1, INDEX_AFTER_KEY, PH_INDEX},
      '{KIND_WRITE, REG_LPT, 1'b1, 8'h00, PH_DATA},
      // data read of the parallel port register at its reset value
      '{KIND_READ,  8'h00, 1'b1, 8'h48, PH_IDLE},
      // irq register bit 7 set: irq 5 and its cnfgb readout
      '{KIND_WRITE, KEY_FIRST, 1'b0, 8'h00, PH_IDLE},
      '{KIND_WRITE, KEY_SECOND, 1'b0, 8'h00, PH_IDLE},
      '{KIND_WRITE, REG_IRQ, 1'b0, 8'h00, PH_IDLE},
      '{KIND_WRITE, 8'h80, 1'b0, 8'h00, PH_IDLE},
      // top entry reads zero
      '{KIND_WRITE, KEY_FIRST, 1'b0, 8'h00, PH_IDLE},
      '{KIND_WRITE, KEY_SECOND, 1'b0, 8'h00, PH_IDLE},
      '{KIND_WRITE, 8'hff, 1'b0, 8'h00, PH_IDLE},
      '{KIND_READ,  8'h00, 1'b1, 8'h00, PH_IDLE},
      // all ones into entry zero
      '{KIND_WRITE, KEY_FIRST, 1'b0, 8'h00, PH_IDLE},
      '{KIND_WRITE, KEY_SECOND, 1'b0, 8'h00, PH_IDLE},
      '{KIND_WRITE, 8'h00, 1'b1, 8'h00, PH_DATA},
      '{KIND_WRITE, 8'hff, 1'b1, 8'h00, PH_IDLE},
      // first key repeated where the second belongs, then a stray second key
      '{KIND_WRITE, KEY_FIRST, 1'b1, 8'h00, PH_KEY},
      '{KIND_WRITE, KEY_FIRST, 1'b1, 8'h00, PH_IDLE},
      '{KIND_WRITE, KEY_SECOND, 1'b1, 8'h00, PH_IDLE}
   };

   logic                 clock;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [DATA_W-1:0]    req_tdata  = '0;   // [7:0] write_data
   logic [0:0]           req_tuser  = '0;   // [0] kind
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [RSP_W-1:0]     rsp_tdata;         // [7:0] read_data, [9:8] phase, [10] fdc_enable,
                                            // [11] uart0_enable, [21:12] uart0_base,
                                            // [22] uart1_enable, [32:23] uart1_base,
                                            // [33] lpt_enable, [43:34] lpt_base,
                                            // [47:44] lpt_irq, [50:48] lpt_mode,
                                            // [58:51] lpt_cnfgb
   logic                 csr_valid  = 1'b0;
   logic                 csr_ready;
   logic [DMA_W-1:0]     csr_data   = '0;

   // predictor state: register file, index, phase and the dma jumper
   logic [7:0]           sio_regs [256];
   logic [7:0]           sio_index;
   phase_type            sio_phase;
   logic [DMA_W-1:0]     dma_jumper;

   port_result_type      pending_results [$];
   int                   mismatches  = 0;
   int                   words_sent  = 0;
   int                   send_idle_pct = 0;
   int                   stall_pct     = 0;

   // typed expectation of the word currently on the request bus
   logic                 cur_typed   = 1'b0;
   logic [7:0]           cur_want_rd = '0;
   logic [1:0]           cur_want_phase = '0;

   superio_config_unlock_regs dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // receiver back-pressure, redrawn every cycle
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
   end

   // one port access: phase update, register write, then live decode of the map
   function automatic port_result_type predict_access(input logic kind,
                                                      input logic [7:0] data);
      port_result_type res;
      logic [7:0]      lpt;
      logic [7:0]      irq_reg;
      logic [7:0]      bases;
      res = '0;
      if (kind == KIND_READ) begin
         case (sio_phase)
            PH_INDEX: res.read_data = sio_index;
            PH_DATA: begin
               res.read_data = sio_regs[sio_index];
               sio_phase = PH_IDLE;
            end
            default: res.read_data = IDLE_READ;
         endcase
      end else begin
         case (sio_phase)
            PH_IDLE: begin
               if (data == KEY_FIRST) sio_phase = PH_KEY;
            end
            PH_KEY: begin
               if (data == KEY_SECOND) begin
                  sio_phase = PH_INDEX;
                  sio_index = INDEX_AFTER_KEY;
               end else begin
                  sio_phase = PH_IDLE;
               end
            end
            PH_INDEX: begin
               sio_index = data;
               sio_phase = PH_DATA;
            end
            default: begin
               sio_regs[sio_index] = data;
               sio_phase = PH_IDLE;
            end
         endcase
      end

      lpt     = sio_regs[REG_LPT];
      irq_reg = sio_regs[REG_IRQ];
      bases   = sio_regs[REG_BASES];
      res.phase      = sio_phase;
      res.fdc_en     = sio_regs[REG_FDC][0];
      res.uart0_en   = sio_regs[REG_UART0][0];
      res.uart0_base = bases[4] ? BASE_COM_3E8 : BASE_COM_3F8;
      res.uart1_en   = sio_regs[REG_UART1][0];
      res.uart1_base = bases[1] ? BASE_COM_2E8 : BASE_COM_2F8;
      res.lpt_en     = sio_regs[REG_LPTEN][0];
      case (lpt[3:2])
         2'b10:   res.lpt_base = BASE_LPT_378;
         2'b11:   res.lpt_base = BASE_LPT_278;
         default: res.lpt_base = BASE_LPT_3BC;
      endcase
      res.lpt_irq   = irq_reg[7] ? LPT_IRQ5 : LPT_IRQ7;
      res.lpt_mode  = {~lpt[6], lpt[5], lpt[4]};
      // channels 4 and up are not reported in cnfgb
      res.lpt_cnfgb = (irq_reg[7] ? CNFGB_IRQ5 : CNFGB_IRQ7) |
                      ((dma_jumper < 3'd4) ? {5'b0, dma_jumper} : 8'h00);
      return res;
   endfunction

   function automatic port_result_type unpack_rsp(input logic [RSP_W-1:0] w);
      port_result_type r;
      r.read_data  = w[7:0];
      r.phase      = w[9:8];
      r.fdc_en     = w[10];
      r.uart0_en   = w[11];
      r.uart0_base = w[21:12];
      r.uart1_en   = w[22];
      r.uart1_base = w[32:23];
      r.lpt_en     = w[33];
      r.lpt_base   = w[43:34];
      r.lpt_irq    = w[47:44];
      r.lpt_mode   = w[50:48];
      r.lpt_cnfgb  = w[58:51];
      return r;
   endfunction

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (want !== got) begin
         $display("%0t ns  %s: expected %h, got %h", $time, name, want, got);
         mismatches++;
      end
   endtask

   // scoreboard: results are checked first, then the word accepted this edge is predicted
   always @(posedge clock) begin : scoreboard
      port_result_type want;
      port_result_type got;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = unpack_rsp(rsp_tdata);
            if (pending_results.size() == 0) begin
               $display("%0t ns  result %h arrived with nothing expected", $time, rsp_tdata);
               mismatches++;
            end else begin
               want = pending_results.pop_front();
               check_field("read_data",    want.read_data,  got.read_data);
               check_field("phase",        want.phase,      got.phase);
               check_field("fdc_enable",   want.fdc_en,     got.fdc_en);
               check_field("uart0_enable", want.uart0_en,   got.uart0_en);
               check_field("uart0_base",   want.uart0_base, got.uart0_base);
               check_field("uart1_enable", want.uart1_en,   got.uart1_en);
               check_field("uart1_base",   want.uart1_base, got.uart1_base);
               check_field("lpt_enable",   want.lpt_en,     got.lpt_en);
               check_field("lpt_base",     want.lpt_base,   got.lpt_base);
               check_field("lpt_irq",      want.lpt_irq,    got.lpt_irq);
               check_field("lpt_mode",     want.lpt_mode,   got.lpt_mode);
               check_field("lpt_cnfgb",    want.lpt_cnfgb,  got.lpt_cnfgb);
            end
         end
         if (csr_valid && csr_ready)
            dma_jumper = csr_data;
         if (req_tvalid && req_tready) begin
            want = predict_access(req_tuser[0], req_tdata);
            // directed rows with hand-typed read data and phase replace the predicted ones
            if (cur_typed) begin
               want.read_data = cur_want_rd;
               want.phase     = cur_want_phase;
            end
            pending_results.push_back(want);
         end
      end
   end

   // watchdog: too many cycles without any handshake ends the run
   always @(posedge clock) begin : watchdog
      int quiet_cycles;
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // present one word after a random idle gap; returns at the accepting edge
   task automatic push_word(input logic kind, input logic [7:0] data,
                            input logic typed = 1'b0, input logic [7:0] want_rd = 8'h00,
                            input logic [1:0] want_phase = 2'd0);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid     <= 1'b1;
      req_tdata      <= data;
      req_tuser      <= kind;
      cur_typed      = typed;
      cur_want_rd    = want_rd;
      cur_want_phase = want_phase;
      do @(posedge clock); while (!req_tready);
      words_sent++;
   endtask

   // sender stops and waits until every expected word has come back
   task automatic drain_port;
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_dma(input logic [DMA_W-1:0] chan);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= chan;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // two in five picks are the map registers, the rest anywhere in the file
   function automatic logic [7:0] pick_index;
      logic [7:0] addr;
      if ($urandom_range(0, 99) < 40) begin
         case ($urandom_range(0, 6))
            0:       addr = REG_FDC;
            1:       addr = REG_BASES;
            2:       addr = REG_UART0;
            3:       addr = REG_UART1;
            4:       addr = REG_LPTEN;
            5:       addr = REG_LPT;
            default: addr = REG_IRQ;
         endcase
      end else begin
         addr = 8'($urandom);
      end
      return addr;
   endfunction

   // mostly full unlock sequences, some broken ones, a little noise
   task automatic run_traffic(input int words);
      int target;
      int pick;
      target = words_sent + words;
      while (words_sent < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 80) begin
            push_word(KIND_WRITE, KEY_FIRST);
            if ($urandom_range(0, 99) < 15) push_word(KIND_READ, 8'($urandom));
            push_word(KIND_WRITE, KEY_SECOND);
            if ($urandom_range(0, 99) < 30) push_word(KIND_READ, 8'($urandom));
            push_word(KIND_WRITE, pick_index());
            // register write or register readback
            if (pick < 55) push_word(KIND_WRITE, 8'($urandom));
            else           push_word(KIND_READ, 8'($urandom));
         end else if (pick < 90) begin
            push_word(KIND_WRITE, KEY_FIRST);
            if ($urandom_range(0, 3) == 0) push_word(KIND_WRITE, KEY_FIRST);
            else                           push_word(KIND_WRITE, 8'($urandom));
         end else begin
            push_word(logic'($urandom_range(0, 1)), 8'($urandom));
         end
      end
   endtask

   initial begin
      // predictor starts from the reset image of the register file
      for (int i = 0; i < 256; i++) sio_regs[i] = 8'h00;
      sio_regs[REG_FDC]   = 8'h01;
      sio_regs[REG_UART0] = 8'h01;
      sio_regs[REG_UART1] = 8'h01;
      sio_regs[REG_LPTEN] = 8'h01;
      sio_regs[REG_BASES] = 8'h10;
      sio_regs[REG_LPT]   = 8'h48;
      sio_index  = 8'h00;
      sio_phase  = PH_IDLE;
      dma_jumper = 3'd3;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // no idling: directed rows then random sequences, dma channel at its low end
      write_dma(3'd0);
      foreach (DIRECTED[i])
         push_word(DIRECTED[i].kind, DIRECTED[i].data, DIRECTED[i].typed,
                   DIRECTED[i].want_rd, DIRECTED[i].want_phase);
      run_traffic(WORDS_PER_PHASE);

      // slow sender, top channel (drops out of cnfgb)
      drain_port();
      write_dma(3'd7);
      send_idle_pct = 74;
      stall_pct     = 0;
      run_traffic(WORDS_PER_PHASE);

      // stalling receiver, first channel that reads back as zero
      drain_port();
      write_dma(3'd4);
      send_idle_pct = 0;
      stall_pct     = 74;
      run_traffic(WORDS_PER_PHASE);

      // light idling on both sides, back to the reset channel
      drain_port();
      write_dma(3'd3);
      send_idle_pct = 8;
      stall_pct     = 8;
      run_traffic(WORDS_PER_PHASE);

      drain_port();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_results.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
